// File: design/smtpdd_pkg.sv
// Shared types, constants and helper functions for the SMTP DATA destuffer.
package smtpdd_pkg;

  // Width of the internal hop counter; the reported count saturates at 255.
  localparam int HOP_COUNT_WIDTH = 8;
  localparam logic [HOP_COUNT_WIDTH-1:0] HOP_MAX = '1;

  // Depth of the work queue between the front and back parts.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // Configuration register indexes.
  localparam logic CFG_SIZE_LIMIT = 1'b0;
  localparam logic CFG_HOP_LIMIT  = 1'b1;

  localparam logic [31:0] SIZE_LIMIT_RESET = 32'd0;
  localparam logic [7:0]  HOP_LIMIT_RESET  = 8'd100;

  // Character codes.
  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_DOT = 8'h2E;

  // Kind of work handed from the front part to the back part.
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_END   = 2'd1;
  localparam logic [1:0] KIND_STRAY = 2'd2;

  typedef logic [HOP_COUNT_WIDTH-1:0] hop_t;

  // One queued job: up to three output words caused by one input byte.
  typedef struct packed {
    logic [1:0]       kind;
    logic [1:0]       count;
    logic [2:0][7:0]  bytes;
    hop_t             hops;
  } job_t;

  // Lower and upper case letters of "delivered" and "received".
  function automatic logic [7:0] dlv_lower(input logic [3:0] p);
    case (p)
      4'd0: return "d";
      4'd1: return "e";
      4'd2: return "l";
      4'd3: return "i";
      4'd4: return "v";
      4'd5: return "e";
      4'd6: return "r";
      4'd7: return "e";
      4'd8: return "d";
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] dlv_upper(input logic [3:0] p);
    case (p)
      4'd0: return "D";
      4'd1: return "E";
      4'd2: return "L";
      4'd3: return "I";
      4'd4: return "V";
      4'd5: return "E";
      4'd6: return "R";
      4'd7: return "E";
      4'd8: return "D";
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] rcv_lower(input logic [3:0] p);
    case (p)
      4'd0: return "r";
      4'd1: return "e";
      4'd2: return "c";
      4'd3: return "e";
      4'd4: return "i";
      4'd5: return "v";
      4'd6: return "e";
      4'd7: return "d";
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] rcv_upper(input logic [3:0] p);
    case (p)
      4'd0: return "R";
      4'd1: return "E";
      4'd2: return "C";
      4'd3: return "E";
      4'd4: return "I";
      4'd5: return "V";
      4'd6: return "E";
      4'd7: return "D";
      default: return 8'h00;
    endcase
  endfunction

  // Hop count as reported: limited to 255.
  function automatic logic [7:0] hop_show(input hop_t h);
    logic [HOP_COUNT_WIDTH+7:0] w;
    w = {8'd0, h};
    if (w > (HOP_COUNT_WIDTH+8)'(255)) return 8'hFF;
    return w[7:0];
  endfunction

  // True when the hop count has reached the limit.
  function automatic logic hop_reached(input hop_t h, input logic [7:0] limit);
    logic [HOP_COUNT_WIDTH+7:0] wh;
    logic [HOP_COUNT_WIDTH+7:0] wl;
    wh = {8'd0, h};
    wl = {{HOP_COUNT_WIDTH{1'b0}}, limit};
    return wh >= wl;
  endfunction

endpackage

// File: design/smtp_data_destuffer.sv
// Top level of the SMTP DATA destuffer: configuration registers and the three parts.
//
//  Channel  Direction  Handshake              Contents
//  in       input      in_valid / in_ready    in_byte, one raw DATA byte per word
//  out      output     out_valid / out_ready  has_byte, out_byte, last, message_end,
//                                             stray_newline, hop_count, too_many_hops,
//                                             size_exceeded
//  cfg      input      cfg_we (no wait)       cfg_index, cfg_data
//
// The back part sends one output word per cycle unless out_ready holds it. An
// input byte causes one word in most cases, none for a held CR or dot, and
// two or three when held bytes are released. The job of a byte is written
// into the queue and then into the output register. A four-entry job queue lets
// the front keep taking bytes while the back is busy with an expansion or the
// output is stalled; in_ready drops only when the queue is full. Reset is
// synchronous.
//
// The front part scans framing and the header and turns each byte into a job of
// up to three words. The back part holds the byte budget for the size limit and
// fills the output register, which keeps its word while out_ready is low. A
// message end or a stray LF gives one word without a byte; the block then starts
// a new message, while the configuration registers keep their values.
module smtp_data_destuffer import smtpdd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        has_byte,
  output logic [7:0]  out_byte,
  output logic        last,
  output logic        message_end,
  output logic        stray_newline,
  output logic [7:0]  hop_count,
  output logic        too_many_hops,
  output logic        size_exceeded,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  logic [31:0] size_limit;
  logic [7:0]  hop_limit;
  logic        size_write;

  logic push;
  logic push_ready;
  job_t push_job;
  logic pop;
  logic head_valid;
  job_t head_job;

  assign size_write = cfg_we && (cfg_index == CFG_SIZE_LIMIT);

  // Configuration registers; the size limit also reloads the byte budget.
  always_ff @(posedge clk) begin
    if (rst) begin
      size_limit <= SIZE_LIMIT_RESET;
      hop_limit  <= HOP_LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SIZE_LIMIT: size_limit <= cfg_data;
        CFG_HOP_LIMIT:  hop_limit  <= cfg_data[7:0];
        default:        hop_limit  <= hop_limit;
      endcase
    end
  end

  smtpdd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .push       (push),
    .push_job   (push_job),
    .push_ready (push_ready)
  );

  smtpdd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .push_ready (push_ready),
    .pop        (pop),
    .head_job   (head_job),
    .head_valid (head_valid)
  );

  smtpdd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head_job      (head_job),
    .pop           (pop),
    .size_limit    (size_limit),
    .hop_limit     (hop_limit),
    .size_write    (size_write),
    .size_value    (cfg_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .has_byte      (has_byte),
    .out_byte      (out_byte),
    .last          (last),
    .message_end   (message_end),
    .stray_newline (stray_newline),
    .hop_count     (hop_count),
    .too_many_hops (too_many_hops),
    .size_exceeded (size_exceeded)
  );

endmodule

// File: design/smtpdd_front.sv
// Front part: accepts input bytes, tracks framing and header state, queues jobs.
module smtpdd_front import smtpdd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       push,
  output job_t       push_job,
  input  logic       push_ready
);

  localparam logic [2:0] FS_MID   = 3'd0;
  localparam logic [2:0] FS_START = 3'd1;
  localparam logic [2:0] FS_DOT   = 3'd2;
  localparam logic [2:0] FS_DOTCR = 3'd3;
  localparam logic [2:0] FS_CR    = 3'd4;

  logic [2:0] frame_state, frame_state_next;
  logic       in_header, in_header_next;
  logic [3:0] line_position, line_position_next;
  logic       may_be_received, may_be_received_next;
  logic       may_be_delivered, may_be_delivered_next;
  logic       may_be_blank_line, may_be_blank_line_next;
  hop_t       hops_seen, hops_seen_next;

  logic       take;
  logic       is_nl;
  logic       is_cr;
  logic       restart;
  logic [2:0] st;
  job_t       job;
  logic       emit;

  assign in_ready = push_ready;
  assign take     = in_valid && in_ready;
  assign is_nl    = (in_byte == CHAR_LF);
  assign is_cr    = (in_byte == CHAR_CR);

  always_comb begin
    in_header_next         = in_header;
    line_position_next     = line_position;
    may_be_received_next   = may_be_received;
    may_be_delivered_next  = may_be_delivered;
    may_be_blank_line_next = may_be_blank_line;
    hops_seen_next         = hops_seen;

    // Header scan: match the start of each line against the hop keywords.
    if (in_header) begin
      if (line_position < 4'd9) begin
        if (in_byte != dlv_lower(line_position) && in_byte != dlv_upper(line_position))
          may_be_delivered_next = 1'b0;
        if (may_be_delivered_next && line_position == 4'd8 && hops_seen != HOP_MAX)
          hops_seen_next = hops_seen + 1'b1;
        if (line_position < 4'd8 && in_byte != rcv_lower(line_position) &&
            in_byte != rcv_upper(line_position))
          may_be_received_next = 1'b0;
        if (may_be_received_next && line_position == 4'd7 && hops_seen != HOP_MAX)
          hops_seen_next = hops_seen + 1'b1;
        if (line_position < 4'd2 &&
            in_byte != ((line_position == 4'd0) ? CHAR_CR : CHAR_LF))
          may_be_blank_line_next = 1'b0;
        if (may_be_blank_line_next && line_position == 4'd1)
          in_header_next = 1'b0;
        line_position_next = line_position + 4'd1;
      end
      if (is_nl) begin
        line_position_next     = 4'd0;
        may_be_received_next   = 1'b1;
        may_be_delivered_next  = 1'b1;
        may_be_blank_line_next = 1'b1;
      end
    end
  end

  always_comb begin
    st               = (frame_state > FS_CR) ? FS_MID : frame_state;
    frame_state_next = frame_state;
    restart          = 1'b0;
    emit             = 1'b0;
    job.kind         = KIND_DATA;
    job.count        = 2'd1;
    job.bytes        = '0;
    job.hops         = hops_seen_next;

    if (is_nl && (st == FS_MID || st == FS_START || st == FS_DOT)) begin
      job.kind = KIND_STRAY;
      emit     = 1'b1;
      restart  = 1'b1;
    end else begin
      case (st)
        FS_MID: begin
          if (is_cr) begin
            frame_state_next = FS_CR;
          end else begin
            emit         = 1'b1;
            job.bytes[0] = in_byte;
          end
        end
        FS_START: begin
          if (in_byte == CHAR_DOT) begin
            frame_state_next = FS_DOT;
          end else if (is_cr) begin
            frame_state_next = FS_CR;
          end else begin
            frame_state_next = FS_MID;
            emit             = 1'b1;
            job.bytes[0]     = in_byte;
          end
        end
        FS_DOT: begin
          if (is_cr) begin
            frame_state_next = FS_DOTCR;
          end else begin
            frame_state_next = FS_MID;
            emit             = 1'b1;
            job.bytes[0]     = in_byte;
          end
        end
        FS_DOTCR: begin
          emit = 1'b1;
          if (is_nl) begin
            job.kind = KIND_END;
            restart  = 1'b1;
          end else begin
            // The held dot and CR were not an end marker: release them.
            job.bytes[0] = CHAR_DOT;
            job.bytes[1] = CHAR_CR;
            if (is_cr) begin
              frame_state_next = FS_CR;
              job.count        = 2'd2;
            end else begin
              frame_state_next = FS_MID;
              job.bytes[2]     = in_byte;
              job.count        = 2'd3;
            end
          end
        end
        default: begin
          // After CR: CRLF becomes LF, a bare CR is kept.
          emit = 1'b1;
          if (is_nl) begin
            frame_state_next = FS_START;
            job.bytes[0]     = in_byte;
          end else if (!is_cr) begin
            frame_state_next = FS_MID;
            job.bytes[0]     = CHAR_CR;
            job.bytes[1]     = in_byte;
            job.count        = 2'd2;
          end else begin
            job.bytes[0] = in_byte;
          end
        end
      endcase
    end
  end

  assign push     = take && emit;
  assign push_job = job;

  always_ff @(posedge clk) begin
    if (rst || (take && restart)) begin
      frame_state       <= FS_START;
      in_header         <= 1'b1;
      line_position     <= 4'd0;
      may_be_received   <= 1'b1;
      may_be_delivered  <= 1'b1;
      may_be_blank_line <= 1'b1;
      hops_seen         <= '0;
    end else if (take) begin
      frame_state       <= frame_state_next;
      in_header         <= in_header_next;
      line_position     <= line_position_next;
      may_be_received   <= may_be_received_next;
      may_be_delivered  <= may_be_delivered_next;
      may_be_blank_line <= may_be_blank_line_next;
      hops_seen         <= hops_seen_next;
    end
  end

endmodule

// File: design/smtpdd_queue.sv
// Short job queue between the front and back parts.
module smtpdd_queue import smtpdd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic push_ready,
  input  logic pop,
  output job_t head_job,
  output logic head_valid
);

  job_t                slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   fill;

  assign push_ready = (fill != (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign head_valid = (fill != '0);
  assign head_job   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      fill <= fill + 1'b1;
      else if (!push && pop) fill <= fill - 1'b1;
    end
  end

endmodule

// File: design/smtpdd_back.sv
// Back part: expands queued jobs into output words and tracks the size limit.
module smtpdd_back import smtpdd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        head_valid,
  input  job_t        head_job,
  output logic        pop,
  input  logic [31:0] size_limit,
  input  logic [7:0]  hop_limit,
  input  logic        size_write,
  input  logic [31:0] size_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        has_byte,
  output logic [7:0]  out_byte,
  output logic        last,
  output logic        message_end,
  output logic        stray_newline,
  output logic [7:0]  hop_count,
  output logic        too_many_hops,
  output logic        size_exceeded
);

  logic [1:0]  word_index;
  logic [32:0] bytes_left;
  logic        over_size;
  logic        load;
  logic        fire;
  logic        final_word;
  logic        is_data;
  logic [32:0] bytes_left_next;
  logic        over_size_next;
  logic [32:0] reload_cur;
  logic [32:0] reload_new;

  assign load       = !out_valid || out_ready;
  assign fire       = load && head_valid;
  assign final_word = (word_index == head_job.count - 2'd1);
  assign is_data    = (head_job.kind == KIND_DATA);
  assign pop        = fire && final_word;

  assign reload_cur = (size_limit == '0) ? '0 : {1'b0, size_limit} + 33'd1;
  assign reload_new = (size_value == '0) ? '0 : {1'b0, size_value} + 33'd1;

  // Byte budget after this word; a budget of zero means no limit.
  always_comb begin
    bytes_left_next = bytes_left;
    over_size_next  = over_size;
    if (is_data && bytes_left != '0) begin
      bytes_left_next = bytes_left - 33'd1;
      if (bytes_left == 33'd1) over_size_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      word_index <= '0;
      bytes_left <= '0;
      over_size  <= 1'b0;
    end else begin
      if (load) out_valid <= head_valid;
      if (fire) word_index <= final_word ? 2'd0 : word_index + 2'd1;
      if (size_write) begin
        bytes_left <= reload_new;
        over_size  <= 1'b0;
      end else if (fire) begin
        if (is_data) begin
          bytes_left <= bytes_left_next;
          over_size  <= over_size_next;
        end else begin
          bytes_left <= reload_cur;
          over_size  <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      has_byte      <= is_data;
      out_byte      <= is_data ? head_job.bytes[word_index] : 8'h00;
      last          <= final_word;
      message_end   <= (head_job.kind == KIND_END);
      stray_newline <= (head_job.kind == KIND_STRAY);
      hop_count     <= hop_show(head_job.hops);
      too_many_hops <= hop_reached(head_job.hops, hop_limit);
      size_exceeded <= is_data ? over_size_next : over_size;
    end
  end

endmodule

// File: design/smtpdd_checker.sv
// Port checker for the SMTP DATA destuffer and its bind statement.
module smtpdd_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic [7:0] in_byte,
  input logic       out_valid,
  input logic       out_ready,
  input logic       has_byte,
  input logic [7:0] out_byte,
  input logic       last,
  input logic       message_end,
  input logic       stray_newline,
  input logic [7:0] hop_count,
  input logic       too_many_hops,
  input logic       size_exceeded
);

  // A stalled output word holds.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last) &&
      $stable(has_byte) && $stable(message_end) && $stable(stray_newline) &&
      $stable(hop_count) && $stable(too_many_hops) && $stable(size_exceeded))
    else $error("stalled output word changed");

  // End and abort never come together.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(message_end && stray_newline))
    else $error("message end and stray newline in one word");

  // An end or abort word carries no byte and closes its input byte.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (message_end || stray_newline) |-> last && !has_byte)
    else $error("end word malformed");

  // A word without a byte shows zero in the byte field.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_byte |-> out_byte == 8'h00)
    else $error("empty word with nonzero byte");

  // A waiting input word keeps its byte.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(in_byte))
    else $error("waiting input word changed");

endmodule

bind smtp_data_destuffer smtpdd_checker u_smtpdd_checker (.*);

// File: bench/tb_smtp_data_destuffer.sv
// Self-checking testbench for the SMTP DATA destuffer: directed and random byte streams.
`timescale 1ns / 1ps

// Every accepted input word is run through a model of the destuffer that is
// kept inside this bench. The model pushes the output words that the byte
// must cause onto a queue. A checker compares each accepted output word with
// the oldest entry of that queue. Test tasks run one after another from a
// single initial block and share the byte sender and the register writer.
module tb_smtp_data_destuffer;
  import smtpdd_pkg::*;

  // Cycles to let pass after the last expected word before touching the
  // registers. A held CR or dot causes no word, so this covers the pipeline.
  localparam int SETTLE_CYCLES = 8;
  // Run limit in clock cycles. The slowest correct run is far below this.
  localparam int CYCLE_LIMIT = 200000;

  // Letters of the two header words that count as a hop.
  localparam logic [71:0] DLV_LOWER = "delivered";
  localparam logic [71:0] DLV_UPPER = "DELIVERED";
  localparam logic [63:0] RCV_LOWER = "received";
  localparam logic [63:0] RCV_UPPER = "RECEIVED";

  // Framing state of the model.
  typedef enum logic [2:0] {
    FR_MID   = 3'd0,
    FR_START = 3'd1,
    FR_DOT   = 3'd2,
    FR_DOTCR = 3'd3,
    FR_CR    = 3'd4
  } frame_t;

  // How the two sides idle during a phase.
  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  // One output word as the block should present it.
  typedef struct packed {
    logic       has_byte;
    logic [7:0] out_byte;
    logic       last;
    logic       message_end;
    logic       stray_newline;
    logic [7:0] hop_count;
    logic       too_many_hops;
    logic       size_exceeded;
  } word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        has_byte;
  logic [7:0]  out_byte;
  logic        last;
  logic        message_end;
  logic        stray_newline;
  logic [7:0]  hop_count;
  logic        too_many_hops;
  logic        size_exceeded;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [31:0] cfg_data = 32'd0;

  smtp_data_destuffer dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_byte       (in_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .has_byte      (has_byte),
    .out_byte      (out_byte),
    .last          (last),
    .message_end   (message_end),
    .stray_newline (stray_newline),
    .hop_count     (hop_count),
    .too_many_hops (too_many_hops),
    .size_exceeded (size_exceeded),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // 20 ns period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Output words still owed by the block, oldest first.
  word_t expected_words[$];

  int fail_count   = 0;
  int cycle_count  = 0;
  int sent_count   = 0;
  int sender_pct   = 0;
  int receiver_pct = 0;
  // Remaining cycles of a forced receiver hold-off.
  int hold_left    = 0;

  // Model copy of the registers.
  logic [31:0] reg_size_limit;
  logic [7:0]  reg_hop_limit;

  // Model copy of the block state.
  frame_t      frame;
  bit          hdr_open;
  logic [3:0]  line_pos;
  bit          rcv_possible;
  bit          dlv_possible;
  bit          blank_possible;
  hop_t        hops;
  logic [32:0] budget;
  bit          oversize;
  // Words pushed for the byte now being modeled.
  int          step_words;

  // ------------------------------------------------------------------
  // Destuffer model
  // ------------------------------------------------------------------

  function automatic logic [32:0] budget_load();
    return (reg_size_limit == 32'd0) ? 33'd0 : {1'b0, reg_size_limit} + 33'd1;
  endfunction

  // The whole per-message state returns to its start; registers are kept.
  task automatic start_message();
    frame          = FR_START;
    hdr_open       = 1'b1;
    line_pos       = 4'd0;
    rcv_possible   = 1'b1;
    dlv_possible   = 1'b1;
    blank_possible = 1'b1;
    hops           = '0;
    budget         = budget_load();
    oversize       = 1'b0;
  endtask

  function automatic bit dlv_hit(input int p, input logic [7:0] c);
    return (c == DLV_LOWER[8*(8-p) +: 8]) || (c == DLV_UPPER[8*(8-p) +: 8]);
  endfunction

  function automatic bit rcv_hit(input int p, input logic [7:0] c);
    return (c == RCV_LOWER[8*(7-p) +: 8]) || (c == RCV_UPPER[8*(7-p) +: 8]);
  endfunction

  task automatic count_hop();
    if (hops != HOP_MAX) hops = hops + 1'b1;
  endtask

  // Status fields are running values taken after this byte's header update.
  task automatic push_word(input bit has, input logic [7:0] b, input bit fin, input bit stray);
    word_t w;
    w.has_byte      = has;
    w.out_byte      = has ? b : 8'h00;
    w.last          = 1'b0;
    w.message_end   = fin;
    w.stray_newline = stray;
    w.hop_count     = (int'(hops) > 255) ? 8'hFF : 8'(hops);
    w.too_many_hops = int'(hops) >= int'(reg_hop_limit);
    w.size_exceeded = oversize;
    expected_words.push_back(w);
    step_words++;
  endtask

  // A delivered byte uses up one unit of the size budget first.
  task automatic deliver(input logic [7:0] b);
    if (budget != 33'd0) begin
      budget = budget - 33'd1;
      if (budget == 33'd0) oversize = 1'b1;
    end
    push_word(1'b1, b, 1'b0, 1'b0);
  endtask

  task automatic predict_byte(input logic [7:0] c);
    frame_t st;
    int     p;
    bit     nl;
    bit     cr;
    word_t  w;
    st         = frame;
    nl         = (c == CHAR_LF);
    cr         = (c == CHAR_CR);
    step_words = 0;

    // Header scan: only the first nine bytes of a line are looked at.
    if (hdr_open) begin
      p = int'(line_pos);
      if (p < 9) begin
        if (!dlv_hit(p, c)) dlv_possible = 1'b0;
        if (dlv_possible && p == 8) count_hop();
        if (p < 8 && !rcv_hit(p, c)) rcv_possible = 1'b0;
        if (rcv_possible && p == 7) count_hop();
        if (p < 2 && c != ((p == 0) ? CHAR_CR : CHAR_LF)) blank_possible = 1'b0;
        if (blank_possible && p == 1) hdr_open = 1'b0;
        line_pos = 4'(p + 1);
      end
      if (nl) begin
        line_pos       = 4'd0;
        rcv_possible   = 1'b1;
        dlv_possible   = 1'b1;
        blank_possible = 1'b1;
      end
    end

    if (nl && (st == FR_MID || st == FR_START || st == FR_DOT)) begin
      // An LF with no CR in front of it aborts the message.
      push_word(1'b0, 8'h00, 1'b0, 1'b1);
      start_message();
    end else if (nl && st == FR_DOTCR) begin
      // CR LF dot CR LF: the end marker.
      push_word(1'b0, 8'h00, 1'b1, 1'b0);
      start_message();
    end else begin
      case (st)
        FR_START: begin
          if (c == CHAR_DOT) begin
            frame = FR_DOT;
          end else if (cr) begin
            frame = FR_CR;
          end else begin
            frame = FR_MID;
            deliver(c);
          end
        end
        FR_DOT: begin
          // A dot at line start is dropped unless a CR follows it.
          if (cr) begin
            frame = FR_DOTCR;
          end else begin
            frame = FR_MID;
            deliver(c);
          end
        end
        FR_DOTCR: begin
          // Not the end marker after all: release the held dot and CR.
          deliver(CHAR_DOT);
          deliver(CHAR_CR);
          if (cr) begin
            frame = FR_CR;
          end else begin
            frame = FR_MID;
            deliver(c);
          end
        end
        FR_CR: begin
          // CR LF becomes LF; a bare CR is kept.
          if (nl) begin
            frame = FR_START;
          end else if (!cr) begin
            deliver(CHAR_CR);
            frame = FR_MID;
          end
          deliver(c);
        end
        default: begin
          if (cr) begin
            frame = FR_CR;
          end else begin
            deliver(c);
          end
        end
      endcase
    end

    if (step_words > 0) begin
      w = expected_words.pop_back();
      w.last = 1'b1;
      expected_words.push_back(w);
    end
  endtask

  // Field by field text of one output word for the reports.
  function automatic string word_text(input word_t w);
    return $sformatf("has=%0b byte=%02h last=%0b end=%0b stray=%0b hops=%0d many=%0b over=%0b",
                     w.has_byte, w.out_byte, w.last, w.message_end, w.stray_newline,
                     w.hop_count, w.too_many_hops, w.size_exceeded);
  endfunction

  // ------------------------------------------------------------------
  // Drivers
  // ------------------------------------------------------------------

  task automatic set_idle(input idle_mode_t mode);
    case (mode)
      IDLE_SENDER: begin
        sender_pct   = 56;
        receiver_pct = 0;
      end
      IDLE_RECEIVER: begin
        sender_pct   = 0;
        receiver_pct = 56;
      end
      IDLE_BOTH: begin
        sender_pct   = 19;
        receiver_pct = 19;
      end
      default: begin
        sender_pct   = 0;
        receiver_pct = 0;
      end
    endcase
  endtask

  // Offers one word and returns at the edge where it is accepted. The valid
  // stays high afterward so that back-to-back words need no low cycle.
  task automatic send_word(input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(0, 99) < sender_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_byte  = b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_byte(b);
    sent_count++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i]);
  endtask

  task automatic send_crlf();
    send_word(CHAR_CR);
    send_word(CHAR_LF);
  endtask

  // The end marker, sent from the start of a line.
  task automatic end_message();
    send_word(CHAR_DOT);
    send_crlf();
  endtask

  // Lowers valid and waits until every owed word has come out, plus a margin
  // for bytes that are still held inside the block without a word.
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register writes happen only with the block idle.
  task automatic write_reg(input logic idx, input logic [31:0] value);
    wait_idle();
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(posedge clk);
    if (idx == CFG_SIZE_LIMIT) begin
      // A new size limit restarts the byte count, even in mid message.
      reg_size_limit = value;
      budget         = budget_load();
      oversize       = 1'b0;
    end else begin
      reg_hop_limit = value[7:0];
    end
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Sends a prefix of one of the hop words, each letter in a random case.
  task automatic send_hop_word(input bit use_delivered, input int keep);
    logic [7:0] c;
    int         n;
    n = use_delivered ? 9 : 8;
    if (keep < n) n = keep;
    for (int i = 0; i < n; i++) begin
      c = use_delivered ? DLV_LOWER[8*(8-i) +: 8] : RCV_LOWER[8*(7-i) +: 8];
      if ($urandom_range(0, 1) == 1) c = c - 8'h20;
      send_word(c);
    end
  endtask

  // Random line content. Mostly LF-free, so that most lines survive.
  task automatic send_random_bytes(input int n);
    logic [7:0] b;
    repeat (n) begin
      b = 8'($urandom_range(0, 255));
      if (b == CHAR_LF && $urandom_range(0, 7) != 0) b = 8'h8A;
      send_word(b);
    end
  endtask

  task automatic send_letters(input int n);
    repeat (n) send_word(8'($urandom_range(8'h20, 8'h7E)));
  endtask

  // Bytes weighted toward the framing characters.
  task automatic send_noise(input int n);
    int pick;
    repeat (n) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) send_word(CHAR_LF);
      else if (pick == 1) send_word(CHAR_CR);
      else if (pick == 2) send_word(CHAR_DOT);
      else send_word(8'($urandom_range(0, 255)));
    end
  endtask

  // A message with a header, a blank line and a body. Now and then the end
  // marker is left out so that the next message runs into this one.
  task automatic send_random_message();
    int kind;
    repeat ($urandom_range(0, 2)) begin
      kind = $urandom_range(0, 3);
      if (kind == 0) begin
        send_hop_word(1'b0, 8);
        send_letters($urandom_range(0, 4));
      end else if (kind == 1) begin
        send_hop_word(1'b1, 9);
        send_letters($urandom_range(0, 4));
      end else if (kind == 2) begin
        // Near misses: a cut-off hop word followed by other letters.
        send_hop_word($urandom_range(0, 1), $urandom_range(0, 8));
        send_letters($urandom_range(0, 3));
      end else begin
        send_letters($urandom_range(0, 10));
      end
      send_crlf();
    end
    send_crlf();
    repeat ($urandom_range(1, 2)) begin
      if ($urandom_range(0, 3) == 0) send_word(CHAR_DOT);
      if ($urandom_range(0, 5) == 0) send_hop_word($urandom_range(0, 1), 9);
      send_random_bytes($urandom_range(0, 8));
      send_crlf();
    end
    if ($urandom_range(0, 7) != 0) end_message();
  endtask

  // ------------------------------------------------------------------
  // Receiver and checker
  // ------------------------------------------------------------------

  // Ready changes at the falling edge; a forced hold-off takes priority.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready = 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ready = ($urandom_range(0, 99) >= receiver_pct);
    end
  end

  always @(posedge clk) begin
    word_t got;
    word_t want;
    if (!rst && out_valid && out_ready) begin
      got = '{has_byte, out_byte, last, message_end, stray_newline,
              hop_count, too_many_hops, size_exceeded};
      if (expected_words.size() == 0) begin
        fail_count++;
        $display("%0t: word with nothing expected, actual %s", $time, word_text(got));
      end else begin
        want = expected_words.pop_front();
        if (got !== want) begin
          fail_count++;
          $display("%0t: mismatch expected %s", $time, word_text(want));
          $display("%0t:          actual   %s", $time, word_text(got));
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // ------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------

  // Held CR and dot, dot unstuffing, bare CR, released dot CR pairs, the
  // three kinds of stray LF and the end marker, plus the byte extremes.
  task automatic test_framing();
    send_word(CHAR_DOT);
    send_word(CHAR_DOT);
    send_word("a");
    send_word(8'h00);
    send_word(8'hFF);
    send_word(CHAR_CR);
    send_word("b");
    send_word(CHAR_CR);
    send_word(CHAR_CR);
    send_word(CHAR_LF);
    send_word(CHAR_DOT);
    send_word(CHAR_CR);
    send_word("x");
    send_crlf();
    send_word(CHAR_DOT);
    send_word(CHAR_CR);
    send_word(CHAR_CR);
    send_word(CHAR_LF);
    send_word(CHAR_DOT);
    send_word(CHAR_LF);
    send_word("z");
    send_word(CHAR_LF);
    send_word(CHAR_LF);
    end_message();
  endtask

  // Hop words in mixed case count only in the header, and only when the
  // whole word is there at the start of the line.
  task automatic test_header_hops();
    send_text("ReCeIvEd: a");
    send_crlf();
    send_text("dElIvErEd: b");
    send_crlf();
    send_text("Receivex");
    send_crlf();
    send_text("Delivere");
    send_crlf();
    send_text(" Received");
    send_crlf();
    send_crlf();
    send_text("Received");
    send_crlf();
    end_message();
  endtask

  task automatic test_size_limit();
    write_reg(CFG_SIZE_LIMIT, 32'd3);
    send_text("abcd");
    send_crlf();
    end_message();
    write_reg(CFG_SIZE_LIMIT, 32'd1);
    send_text("q");
    // A write in mid message restarts the count and clears the flag.
    write_reg(CFG_SIZE_LIMIT, 32'd5);
    send_text("rstuvw");
    send_crlf();
    end_message();
    write_reg(CFG_SIZE_LIMIT, 32'd4294967294);
    send_text("big");
    send_crlf();
    end_message();
    write_reg(CFG_SIZE_LIMIT, 32'd0);
    send_text("free");
    send_crlf();
    end_message();
  endtask

  task automatic test_hop_limit();
    write_reg(CFG_HOP_LIMIT, 32'd1);
    send_text("Received x");
    send_crlf();
    send_crlf();
    send_text("hi");
    send_crlf();
    end_message();
    // A limit of zero is always reached.
    write_reg(CFG_HOP_LIMIT, 32'd0);
    send_text("hi");
    send_crlf();
    end_message();
    write_reg(CFG_HOP_LIMIT, 32'd100);
  endtask

  // The receiver holds off long enough for the job queue to fill while the
  // sender keeps offering words without a gap.
  task automatic test_output_hold();
    wait_idle();
    set_idle(IDLE_NONE);
    hold_left = 200;
    send_text("Received: hold");
    send_crlf();
    send_crlf();
    send_word(CHAR_DOT);
    send_word(CHAR_CR);
    send_word("y");
    send_text("more body");
    send_crlf();
    end_message();
  endtask

  // The sender stops in mid line until every owed word is out.
  task automatic test_sender_pause();
    send_crlf();
    send_text("Hello");
    send_word(CHAR_CR);
    wait_idle();
    send_text(" world");
    send_crlf();
    send_word(CHAR_DOT);
    send_word(CHAR_CR);
    wait_idle();
    send_word(CHAR_LF);
  endtask

  // Random messages and noise under each idling pattern.
  task automatic test_random_phase(input idle_mode_t mode, input logic [31:0] size_value,
                                   input logic [31:0] hop_value, input int item_goal);
    int first;
    write_reg(CFG_SIZE_LIMIT, size_value);
    write_reg(CFG_HOP_LIMIT, hop_value);
    set_idle(mode);
    first = sent_count;
    while (sent_count - first < item_goal) begin
      if ($urandom_range(0, 4) == 0) send_noise($urandom_range(1, 6));
      send_random_message();
    end
    wait_idle();
    set_idle(IDLE_NONE);
  endtask

  initial begin
    reg_size_limit = SIZE_LIMIT_RESET;
    reg_hop_limit  = HOP_LIMIT_RESET;
    start_message();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_framing();
    test_header_hops();
    test_size_limit();
    test_hop_limit();
    test_output_hold();
    test_sender_pause();
    test_random_phase(IDLE_NONE, 32'd0, 32'd1, 10);
    test_random_phase(IDLE_SENDER, 32'($urandom_range(1, 30)), 32'($urandom_range(1, 4)), 10);
    test_random_phase(IDLE_RECEIVER, 32'd4294967294, 32'd255, 10);
    test_random_phase(IDLE_BOTH, 32'($urandom_range(1, 60)), 32'd2, 10);

    wait_idle();
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
